// ===== sv/stsq_pkg.sv =====
// Package for the two-phase stepper sequencer: field widths, timing limits
// and the full-step coil pattern table. No dependencies.
package stsq_pkg;

	// Field widths
	localparam int CNT_W   = 16;
	localparam int WAIT_W  = 16;
	localparam int PHASE_W = 2;
	localparam int COIL_W  = 4;

	// Stream payload widths (padded to whole bytes)
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	// Timing limits in milliseconds
	localparam logic [WAIT_W-1:0] MIN_PERIOD = WAIT_W'(2);
	localparam logic [WAIT_W-1:0] MAX_ON_MS  = WAIT_W'(10);

	// Request kinds carried on tuser
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Two-phase full-step coil pattern for each phase index
	function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] pat;
		unique case (ph)
			2'd0: pat = 4'h3;
			2'd1: pat = 4'h6;
			2'd2: pat = 4'hC;
			2'd3: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

// ===== sv/stepper_two_phase_sequencer.sv =====
// Two-phase full-step stepper sequencer, top level.
// Depends on stsq_pkg for widths, timing limits and the coil table.
//
// Usage: each request on the s_axis channel is either a 1 ms tick
// (tuser = 0) or a move command (tuser = 1) carrying direction, step count
// and per-step period. Every request produces exactly one result on m_axis
// showing coil drive, LED, busy flag and steps left after that request.
// A move command that arrives while a move is running, or with a zero step
// count, leaves the state untouched but still yields a result.
// The state update and the result are registered at the edge that accepts the
// request. Throughput is one request per clock unless the receiver stalls;
// the state logic is a single short pass of 16-bit add/compare.
// The result sits in one output register; s_axis_tready stays high while
// that register is empty or being drained in the same cycle, so when the
// receiver stalls the sender is held off after one pending result.
// Reset (arst_n low) clears the move state, sets the period to 2 ms and
// empties the output register.
module stepper_two_phase_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] direction, [16:1] step_count, [32:17] wait_ms, [39:33] zero
	input  logic [stsq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] action
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [3:0] coils, [4] led, [5] busy_res, [21:6] steps_left, [23:22] zero
	output logic [stsq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	// Move state
	logic [stsq_pkg::PHASE_W-1:0] phase_q;
	logic [stsq_pkg::CNT_W-1:0]   remaining_q;
	logic [stsq_pkg::WAIT_W-1:0]  elapsed_q;
	logic [stsq_pkg::WAIT_W-1:0]  period_q;
	logic                         reverse_q;
	logic                         running_q;
	logic                         energized_q;

	// Output register
	logic                         out_valid_q;
	logic [stsq_pkg::COIL_W-1:0]  coils_q;
	logic                         led_q;
	logic                         busy_q;
	logic [stsq_pkg::CNT_W-1:0]   steps_left_q;

	// Request fields
	logic                         in_dir;
	logic [stsq_pkg::CNT_W-1:0]   in_cnt;
	logic [stsq_pkg::WAIT_W-1:0]  in_wait;
	logic                         accept;

	// Next state
	logic [stsq_pkg::PHASE_W-1:0] phase_d;
	logic [stsq_pkg::CNT_W-1:0]   remaining_d;
	logic [stsq_pkg::WAIT_W-1:0]  elapsed_d;
	logic [stsq_pkg::WAIT_W-1:0]  period_d;
	logic                         reverse_d;
	logic                         running_d;
	logic                         energized_d;

	logic [stsq_pkg::WAIT_W-1:0]  on_time;
	logic [stsq_pkg::WAIT_W-1:0]  elapsed_inc;
	logic [stsq_pkg::CNT_W-1:0]   remaining_dec;
	logic                         step_dir;
	logic                         do_step;

	assign in_dir  = s_axis_tdata[0];
	assign in_cnt  = s_axis_tdata[stsq_pkg::CNT_W:1];
	assign in_wait = s_axis_tdata[stsq_pkg::CNT_W+stsq_pkg::WAIT_W:stsq_pkg::CNT_W+1];

	// Handshake: one output register, drained in the same cycle if needed
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign on_time       = (period_q < stsq_pkg::MAX_ON_MS) ? period_q : stsq_pkg::MAX_ON_MS;
	assign elapsed_inc   = elapsed_q + stsq_pkg::WAIT_W'(1);
	assign remaining_dec = remaining_q - stsq_pkg::CNT_W'(1);

	// State update for one request
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		elapsed_d   = elapsed_q;
		period_d    = period_q;
		reverse_d   = reverse_q;
		running_d   = running_q;
		energized_d = energized_q;
		step_dir    = reverse_q;
		do_step     = 1'b0;
		if (s_axis_tuser == stsq_pkg::ACT_START) begin
			if (!running_q && (in_cnt != '0)) begin
				running_d   = 1'b1;
				remaining_d = in_cnt;
				period_d    = (in_wait < stsq_pkg::MIN_PERIOD) ? stsq_pkg::MIN_PERIOD : in_wait;
				reverse_d   = in_dir;
				step_dir    = in_dir;
				do_step     = 1'b1;
			end
		end else if (running_q) begin
			elapsed_d = elapsed_inc;
			if (elapsed_inc >= on_time)
				energized_d = 1'b0;
			if (elapsed_inc >= period_q) begin
				remaining_d = remaining_dec;
				if (remaining_dec == '0) begin
					running_d   = 1'b0;
					energized_d = 1'b0;
					elapsed_d   = '0;
				end else begin
					do_step = 1'b1;
				end
			end
		end
		// Advance the phase and energize for a new step
		if (do_step) begin
			phase_d     = step_dir ? (phase_q - stsq_pkg::PHASE_W'(1))
			                       : (phase_q + stsq_pkg::PHASE_W'(1));
			elapsed_d   = '0;
			energized_d = 1'b1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			remaining_q <= '0;
			elapsed_q   <= '0;
			period_q    <= stsq_pkg::MIN_PERIOD;
			reverse_q   <= 1'b0;
			running_q   <= 1'b0;
			energized_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			elapsed_q   <= elapsed_d;
			period_q    <= period_d;
			reverse_q   <= reverse_d;
			running_q   <= running_d;
			energized_q <= energized_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			coils_q      <= energized_d ? stsq_pkg::coil_pattern(phase_d) : '0;
			led_q        <= energized_d && reverse_d;
			busy_q       <= running_d;
			steps_left_q <= remaining_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, steps_left_q, busy_q, led_q, coils_q};

	// A running move always has steps left
	assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (remaining_q != '0))
		else $error("running with no steps left");

	// Within a step the elapsed time stays below the period
	assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (elapsed_q < period_q))
		else $error("elapsed time reached period");

	// Idle result shows no drive and no steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !busy_q) |-> ((steps_left_q == '0) && (coils_q == '0) && !led_q))
		else $error("idle result shows activity");

	// LED is only lit while coils are driven
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && led_q) |-> (coils_q != '0))
		else $error("led lit with coils off");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the two-phase stepper sequencer: stream driver,
// result monitor and a cycle-free predictor of the coil sequencing.
// Depends on stsq_pkg and stepper_two_phase_sequencer.
`timescale 1ns / 1ps

module testbench;

	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;
	localparam int   CALM_TAIL = 150;

	// Own copy of the full-step drive pattern
	localparam logic [stsq_pkg::COIL_W-1:0] DRIVE_PATTERN [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

	typedef struct {
		logic                        action;
		logic                        dir;
		logic [stsq_pkg::CNT_W-1:0]  cnt;
		logic [stsq_pkg::WAIT_W-1:0] wt;
		bit                          hold;   // wait for all results before sending
	} motor_req_t;

	typedef struct {
		logic [stsq_pkg::COIL_W-1:0] coils;
		logic                        led;
		logic                        busy;
		logic [stsq_pkg::CNT_W-1:0]  left;
	} motor_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [stsq_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [stsq_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	motor_req_t pending_req[$];
	motor_res_t motor_expected[$];
	motor_req_t cur;
	bit hold_next = 1'b0;
	int total = 0;
	int sent = 0;
	int got = 0;
	int mism = 0;
	int gap = 0;
	int stall = 0;
	logic calm = 1'b0;

	// Predicted motor state
	logic [stsq_pkg::PHASE_W-1:0] ph = '0;
	logic [stsq_pkg::CNT_W-1:0]   left = '0;
	logic [stsq_pkg::WAIT_W-1:0]  ms_count = '0;
	logic [stsq_pkg::WAIT_W-1:0]  per = stsq_pkg::MIN_PERIOD;
	logic                         rev = 1'b0;
	logic                         active = 1'b0;
	logic                         coil_on = 1'b0;

	stepper_two_phase_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Advance phase one position in the move direction and energize
	task automatic enter_step();
		ph = rev ? ph - 2'd1 : ph + 2'd1;
		ms_count = '0;
		coil_on = 1'b1;
	endtask

	// Apply one accepted request to the predicted state, queue its result
	task automatic motor_advance(input motor_req_t r);
		motor_res_t o;
		logic [stsq_pkg::WAIT_W-1:0] on_ms;
		if (r.action == stsq_pkg::ACT_START) begin
			if (!active && r.cnt != '0) begin
				active = 1'b1;
				left = r.cnt;
				per = (r.wt < stsq_pkg::MIN_PERIOD) ? stsq_pkg::MIN_PERIOD : r.wt;
				rev = r.dir;
				enter_step();
			end
		end else if (active) begin
			on_ms = (per < stsq_pkg::MAX_ON_MS) ? per : stsq_pkg::MAX_ON_MS;
			ms_count = ms_count + stsq_pkg::WAIT_W'(1);
			if (ms_count >= on_ms)
				coil_on = 1'b0;
			if (ms_count >= per) begin
				left = left - stsq_pkg::CNT_W'(1);
				if (left == '0) begin
					active = 1'b0;
					coil_on = 1'b0;
					ms_count = '0;
				end else begin
					enter_step();
				end
			end
		end
		o.coils = coil_on ? DRIVE_PATTERN[ph] : '0;
		o.led = coil_on & rev;
		o.busy = active;
		o.left = left;
		motor_expected.push_back(o);
	endtask

	task automatic queue_req(input logic action, input logic dir,
			input logic [stsq_pkg::CNT_W-1:0] cnt, input logic [stsq_pkg::WAIT_W-1:0] wt);
		motor_req_t r;
		r.action = action;
		r.dir = dir;
		r.cnt = cnt;
		r.wt = wt;
		r.hold = hold_next;
		hold_next = 1'b0;
		pending_req.push_back(r);
	endtask

	// Ticks carry random junk in the ignored fields
	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_req(stsq_pkg::ACT_TICK, 1'($urandom_range(0, 1)), 16'($urandom),
				16'($urandom));
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			if (mism < 10)
				$display("result %0d %s: expected %0h, got %0h", got, name, want, seen);
			mism++;
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				motor_advance(cur);
				sent++;
			end
			calm <= (sent + CALM_TAIL >= total);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap > 0) begin
					gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_req.size() > 0 && !(pending_req[0].hold && sent != got)) begin
					cur = pending_req.pop_front();
					s_axis_tdata <= {7'd0, cur.wt, cur.cnt, cur.dir};
					s_axis_tuser <= cur.action;
					s_axis_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						gap = $urandom_range(1, 8);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		motor_res_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (motor_expected.size() == 0) begin
					if (mism < 10)
						$display("result %0d with nothing expected: %0h", got, m_axis_tdata);
					mism++;
				end else begin
					e = motor_expected.pop_front();
					check_field("coils", 32'(e.coils), 32'(m_axis_tdata[3:0]));
					check_field("led", 32'(e.led), 32'(m_axis_tdata[4]));
					check_field("busy_res", 32'(e.busy), 32'(m_axis_tdata[5]));
					check_field("steps_left", 32'(e.left), 32'(m_axis_tdata[21:6]));
				end
				got <= got + 1;
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					stall = $urandom_range(1, 8);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int pick;
		int steps;
		int span;
		logic [stsq_pkg::WAIT_W-1:0] wt;

		// Directed: idle tick, zero count, short periods, busy start, wraps
		queue_req(stsq_pkg::ACT_TICK, DIR_CCW, 16'hFFFF, 16'hFFFF);
		queue_req(stsq_pkg::ACT_START, DIR_CCW, 16'h0000, 16'hFFFF);
		queue_req(stsq_pkg::ACT_START, DIR_CW, 16'd1, 16'd0);
		queue_ticks(1);
		queue_req(stsq_pkg::ACT_START, DIR_CCW, 16'hFFFF, 16'hFFFF);
		queue_ticks(1);
		queue_req(stsq_pkg::ACT_START, DIR_CCW, 16'd2, 16'd1);
		queue_ticks(4);
		queue_req(stsq_pkg::ACT_START, DIR_CW, 16'd1, 16'd12);
		queue_ticks(13);
		hold_next = 1'b1;

		// Random: mostly complete moves, some junk starts and idle ticks
		while (pending_req.size() < 1320) begin
			pick = $urandom_range(0, 10);
			if (pick < 8) begin
				steps = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
				case ($urandom_range(0, 4))
					0: wt = stsq_pkg::WAIT_W'($urandom_range(0, 2));
					1: wt = stsq_pkg::WAIT_W'($urandom_range(3, 9));
					2: wt = stsq_pkg::WAIT_W'($urandom_range(10, 11));
					3: wt = stsq_pkg::WAIT_W'($urandom_range(12, 25));
					default: wt = stsq_pkg::WAIT_W'($urandom_range(0, 15));
				endcase
				queue_req(stsq_pkg::ACT_START, 1'($urandom_range(0, 1)), 16'(steps), wt);
				span = steps * ((wt < stsq_pkg::MIN_PERIOD) ? int'(stsq_pkg::MIN_PERIOD)
				                                            : int'(wt));
				for (int j = 0; j < span; j++) begin
					// still running here, so this start is dropped
					if ($urandom_range(0, 19) == 0)
						queue_req(stsq_pkg::ACT_START, 1'($urandom_range(0, 1)),
							16'($urandom), 16'($urandom));
					queue_ticks(1);
				end
				queue_ticks($urandom_range(0, 2));
			end else if (pick == 8) begin
				queue_req(stsq_pkg::ACT_START, 1'($urandom_range(0, 1)), 16'h0000,
					16'($urandom));
			end else if (pick == 9) begin
				queue_ticks($urandom_range(1, 3));
			end else begin
				hold_next = 1'b1;
			end
		end
		total = pending_req.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (got != total)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mism == 0 && motor_expected.size() == 0)
			$display("stepper_two_phase_sequencer regression: pass");
		else
			$display("stepper_two_phase_sequencer regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#(12 * 400000);
		$display("stepper_two_phase_sequencer regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/stsq_pkg.sv
sv/stepper_two_phase_sequencer.sv
bench/testbench.sv
